// ===== hw/rtl/fdts_pkg.sv =====
// ----------------------------------------------------------------------------
// fdts_pkg
// Shared types and constants of the fragment depth test and shade block.
// ----------------------------------------------------------------------------
package fdts_pkg;

  // Item kinds.
  localparam logic KIND_FRAGMENT = 1'b0;
  localparam logic KIND_CLEAR    = 1'b1;

  // Configuration register indexes.
  localparam logic REG_BACKDROP_COLOR = 1'b0;
  localparam logic REG_INSIDE_MARGIN  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] BACKDROP_RESET = 16'd0;
  localparam logic [15:0] MARGIN_RESET   = 16'd655;

  // Farthest depth in Q16.16 and unit weight in Q7.16.
  localparam logic [31:0] FAR_DEPTH  = 32'hFFFF_FFFF;
  localparam int          WEIGHT_ONE = 65536;

  // Largest RGB565 channel values.
  localparam logic [4:0] RB_MAX = 5'h1F;
  localparam logic [5:0] G_MAX  = 6'h3F;

  // One fragment or clear transaction.
  typedef struct packed {
    logic               kind;
    logic [6:0]         pixel_x;
    logic [6:0]         pixel_y;
    logic signed [23:0] weight_a;
    logic signed [23:0] weight_b;
    logic [23:0]        inv_depth_a;
    logic [23:0]        inv_depth_b;
    logic [23:0]        inv_depth_c;
    logic [15:0]        surface_color;
    logic [8:0]         light_level;
  } fdts_in_t;

  // One result transaction.
  typedef struct packed {
    logic [15:0] pixel_color;
    logic        depth_written;
  } fdts_out_t;

endpackage

// ===== hw/rtl/fragment_depth_test_shade.sv =====
// ----------------------------------------------------------------------------
// fragment_depth_test_shade
// Z-buffer depth test and shading of barycentric fragments over one tile.
// ----------------------------------------------------------------------------
// After reset the block sweeps all TILE_WIDTH*TILE_HEIGHT entries (14400 at the
// default size) of its depth and color memories, one entry per cycle, writing
// far depth and black; frag_ready stays low until the sweep is done, while
// configuration writes are taken at any time. Items are then handled one at a
// time. A fragment in the tile that lies inside its triangle and whose weighted
// reciprocal depth sum exceeds 2^24 passes through the restoring divider, which
// produces one quotient bit per cycle. Clear items, outside fragments,
// saturated depths and pixels beyond the tile skip the divider. The memories
// have one write port and a registered read; each item reads its entry once
// and, if it lies in the tile and is a clear or passes the depth test, writes
// it back at the end, so items never overlap on an entry. A finished result
// waits in an output register while the next item is accepted.
module fragment_depth_test_shade
  import fdts_pkg::*;
#(
  parameter int TILE_WIDTH  = 120,
  parameter int TILE_HEIGHT = 120
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        frag_valid,
  output logic        frag_ready,
  input  fdts_in_t    frag,
  output logic        result_valid,
  input  logic        result_ready,
  output fdts_out_t   result
);

  localparam int PIXEL_COUNT = TILE_WIDTH * TILE_HEIGHT;
  localparam int IDX_W       = $clog2(PIXEL_COUNT);
  localparam int CALC_W      = 17;
  localparam int SUM_W       = 52;
  localparam int REM_W       = 51;
  localparam int QUOT_W      = 32;
  localparam int STEP_W      = $clog2(QUOT_W);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_WB    = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] backdrop_color;
  logic [15:0] inside_margin;

  // Captured item.
  logic               item_kind;
  logic               item_in_tile;
  logic               item_inside;
  logic [IDX_W-1:0]   item_idx;
  logic signed [23:0] item_wa;
  logic signed [23:0] item_wb;
  logic signed [25:0] item_wg;
  logic [23:0]        item_ia;
  logic [23:0]        item_ib;
  logic [23:0]        item_ic;
  logic [15:0]        item_color;
  logic [8:0]         item_level;

  // Arithmetic pipeline.
  logic signed [SUM_W-1:0] prod_a;
  logic signed [SUM_W-1:0] prod_b;
  logic signed [SUM_W-1:0] prod_c;
  logic signed [SUM_W-1:0] recip_sum;
  logic [REM_W-1:0]        divisor;
  logic [REM_W-1:0]        rem;
  logic [QUOT_W-1:0]       quot;
  logic [STEP_W-1:0]       step;

  // Memories and their read data.
  logic [31:0]      depth_mem [PIXEL_COUNT];
  logic [15:0]      color_mem [PIXEL_COUNT];
  logic [31:0]      rd_depth;
  logic [15:0]      rd_color;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [31:0]      mem_wdepth;
  logic [15:0]      mem_wcolor;
  logic [IDX_W-1:0] clear_addr;

  // Combinational helpers.
  logic               accept;
  logic               wb_go;
  logic [CALC_W-1:0]  idx_calc;
  logic signed [25:0] wa_ext;
  logic signed [25:0] wb_ext;
  logic signed [25:0] wg_calc;
  logic [REM_W:0]     rem_shift;
  logic [REM_W:0]     rem_diff;
  logic               depth_pass;
  logic               written;
  logic [15:0]        shaded;
  logic [15:0]        color_out;

  // A weight counts as inside when it is greater than minus the margin.
  function automatic logic above_margin(input logic signed [25:0] w,
                                        input logic [15:0] margin);
    logic signed [26:0] t;
    t = 27'(w) + $signed({11'b0, margin});
    return t > 27'sd0;
  endfunction

  // Scales each RGB565 channel by level/256 and saturates it.
  function automatic logic [15:0] shade(input logic [15:0] color,
                                        input logic [8:0] level);
    logic [13:0] b_p;
    logic [14:0] g_p;
    logic [13:0] r_p;
    logic [4:0]  b;
    logic [5:0]  g;
    logic [4:0]  r;
    b_p = 14'(color[4:0]) * 14'(level);
    g_p = 15'(color[10:5]) * 15'(level);
    r_p = 14'(color[15:11]) * 14'(level);
    b = (b_p[13:8] > 6'(RB_MAX)) ? RB_MAX : b_p[12:8];
    g = (g_p[14:8] > 7'(G_MAX)) ? G_MAX : g_p[13:8];
    r = (r_p[13:8] > 6'(RB_MAX)) ? RB_MAX : r_p[12:8];
    return {r, g, b};
  endfunction

  assign frag_ready = (state == ST_IDLE);
  assign accept     = frag_valid && frag_ready;
  assign wb_go      = (state == ST_WB) && (!result_valid || result_ready);

  // Entry address, extended weights and gamma weight from the incoming transaction.
  assign idx_calc = CALC_W'(frag.pixel_x) + CALC_W'(frag.pixel_y) * CALC_W'(TILE_WIDTH);
  assign wa_ext   = 26'(frag.weight_a);
  assign wb_ext   = 26'(frag.weight_b);
  assign wg_calc  = 26'(WEIGHT_ONE) - wa_ext - wb_ext;

  // Sum of the weighted reciprocal depths, settled during ST_SUM.
  assign recip_sum = prod_a + prod_b + prod_c;

  // One restoring division step.
  assign rem_shift = {rem, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  // Final decision and the color held after the transaction.
  assign depth_pass = (item_kind == KIND_FRAGMENT) && item_inside && (quot <= rd_depth);
  assign written    = item_in_tile && ((item_kind == KIND_CLEAR) || depth_pass);
  assign shaded     = shade(item_color, item_level);

  always_comb begin
    if (!item_in_tile) begin
      color_out = 16'd0;
    end else if (item_kind == KIND_CLEAR) begin
      color_out = backdrop_color;
    end else if (depth_pass) begin
      color_out = shaded;
    end else begin
      color_out = rd_color;
    end
  end

  // Write port: the reset sweep or the write-back of a transaction.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we     = 1'b1;
      mem_waddr  = clear_addr;
      mem_wdepth = FAR_DEPTH;
      mem_wcolor = 16'd0;
    end else begin
      mem_we     = wb_go && written;
      mem_waddr  = item_idx;
      mem_wdepth = (item_kind == KIND_CLEAR) ? FAR_DEPTH : quot;
      mem_wcolor = color_out;
    end
  end

  // Depth memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdepth;
    end
    if (state == ST_MUL) begin
      rd_depth <= depth_mem[item_idx];
    end
  end

  // Color memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_mem[mem_waddr] <= mem_wcolor;
    end
    if (state == ST_MUL) begin
      rd_color <= color_mem[item_idx];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      backdrop_color <= BACKDROP_RESET;
      inside_margin  <= MARGIN_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_BACKDROP_COLOR: backdrop_color <= cfg_data;
        REG_INSIDE_MARGIN:  inside_margin  <= cfg_data;
        default:            backdrop_color <= backdrop_color;
      endcase
    end
  end

  // Sequencer, reset sweep and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      result_valid <= 1'b0;
    end else begin
      // A write-back refills the result register even as it drains.
      if (wb_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clear_addr == IDX_W'(PIXEL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
          clear_addr <= clear_addr + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          if ((item_kind == KIND_FRAGMENT) && item_in_tile && item_inside &&
              (recip_sum > SUM_W'(64'sd16777216))) begin
            state <= ST_DIV;
          end else begin
            state <= ST_WB;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(QUOT_W - 1)) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (wb_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture of the accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind    <= frag.kind;
      item_in_tile <= (9'(frag.pixel_x) < 9'(TILE_WIDTH)) &&
                      (9'(frag.pixel_y) < 9'(TILE_HEIGHT));
      item_inside  <= above_margin(wa_ext, inside_margin) &&
                      above_margin(wb_ext, inside_margin) &&
                      above_margin(wg_calc, inside_margin);
      item_idx     <= idx_calc[IDX_W-1:0];
      item_wa      <= frag.weight_a;
      item_wb      <= frag.weight_b;
      item_wg      <= wg_calc;
      item_ia      <= frag.inv_depth_a;
      item_ib      <= frag.inv_depth_b;
      item_ic      <= frag.inv_depth_c;
      item_color   <= frag.surface_color;
      item_level   <= frag.light_level;
    end
  end

  // Weighted reciprocal depths.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod_a <= SUM_W'(item_wa) * SUM_W'($signed({1'b0, item_ia}));
      prod_b <= SUM_W'(item_wb) * SUM_W'($signed({1'b0, item_ib}));
      prod_c <= SUM_W'(item_wg) * SUM_W'($signed({1'b0, item_ic}));
    end
  end

  // Depth = floor(2^56 / sum); the dividend bits above the low 32 give the
  // start remainder 2^24, which is below the divisor, so the quotient fits
  // 32 bits.
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      step <= '0;
      quot <= FAR_DEPTH;
      rem  <= REM_W'(24'hFF_FFFF) + 1'b1;
    end else if (state == ST_DIV) begin
      step <= step + 1'b1;
      if (!rem_diff[REM_W]) begin
        rem  <= rem_diff[REM_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[REM_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
  end

  // Divisor taken once the sum is settled.
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      divisor <= REM_W'(recip_sum);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (wb_go) begin
      result.pixel_color   <= color_out;
      result.depth_written <= written;
    end
  end

endmodule
